/* sv/b64d_pkg.sv */
package b64d_pkg;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned SextWidth  = 6;
   localparam int unsigned GroupWidth = 18;
   localparam int unsigned WordWidth  = 24;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueueIdxW  = $clog2(QueueDepth);

   localparam logic [1:0] LastIdxOne   = 2'd0;
   localparam logic [1:0] LastIdxTwo   = 2'd1;
   localparam logic [1:0] LastIdxThree = 2'd2;

   // One unit of output work: up to three bytes, most significant byte first.
   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic [1:0]           last_idx;
      logic                 has_data;
      logic                 done;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_chan_type;

   // Bit six set means the character is not in the alphabet, which includes '='.
   function automatic logic [SextWidth:0] sextet_of(input logic [CharWidth-1:0] c);
      logic [SextWidth:0] v;
      v = 7'h40;
      case (c) inside
         [8'h41:8'h5a]: v = {1'b0, 6'(c - 8'h41)};
         [8'h61:8'h7a]: v = {1'b0, 6'(c - 8'h61 + 8'd26)};
         [8'h30:8'h39]: v = {1'b0, 6'(c - 8'h30 + 8'd52)};
         8'h2b:         v = 7'd62;
         8'h2f:         v = 7'd63;
         default:       v = 7'h40;
      endcase
      return v;
   endfunction

endpackage

/* sv/b64d_front.sv */
module b64d_front
   import b64d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CharWidth-1:0] req_tdata,
   input  logic                 req_tlast,
   input  logic                 queue_full,
   output job_chan_type         push
);

   logic [GroupWidth-1:0] grp_ff, grp_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  stop_ff, stop_in;

   logic                  accept;
   logic [SextWidth:0]    sext;
   logic                  take;
   logic                  full_group;
   logic [GroupWidth-1:0] nxt_grp;
   logic [1:0]            nxt_cnt;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;
   assign sext       = sextet_of(req_tdata);
   assign take       = !stop_ff && !sext[SextWidth];
   assign full_group = take && (cnt_ff == 2'd3);

   always_comb begin
      nxt_grp = grp_ff;
      nxt_cnt = cnt_ff;
      if (take && !full_group) begin
         nxt_grp = {grp_ff[GroupWidth-SextWidth-1:0], sext[SextWidth-1:0]};
         nxt_cnt = cnt_ff + 2'd1;
      end
   end

   always_comb begin
      push.valid        = accept && (full_group || req_tlast);
      push.job.word     = '0;
      push.job.last_idx = LastIdxOne;
      push.job.has_data = 1'b0;
      push.job.done     = req_tlast;
      if (full_group) begin
         push.job.word     = {grp_ff, sext[SextWidth-1:0]};
         push.job.last_idx = LastIdxThree;
         push.job.has_data = 1'b1;
      end else if (nxt_cnt == 2'd3) begin
         push.job.word     = {nxt_grp, 6'b0};
         push.job.last_idx = LastIdxTwo;
         push.job.has_data = 1'b1;
      end else if (nxt_cnt == 2'd2) begin
         push.job.word     = {nxt_grp[11:0], 12'b0};
         push.job.last_idx = LastIdxOne;
         push.job.has_data = 1'b1;
      end
   end

   always_comb begin
      grp_in  = grp_ff;
      cnt_in  = cnt_ff;
      stop_in = stop_ff;
      if (accept) begin
         if (req_tlast) begin
            grp_in  = '0;
            cnt_in  = '0;
            stop_in = 1'b0;
         end else if (full_group) begin
            grp_in = '0;
            cnt_in = '0;
         end else begin
            grp_in  = nxt_grp;
            cnt_in  = nxt_cnt;
            stop_in = stop_ff || sext[SextWidth];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_ff  <= '0;
         cnt_ff  <= '0;
         stop_ff <= 1'b0;
      end else begin
         grp_ff  <= grp_in;
         cnt_ff  <= cnt_in;
         stop_ff <= stop_in;
      end
   end

endmodule

/* sv/b64d_queue.sv */
module b64d_queue
   import b64d_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  job_chan_type push,
   output logic         full,
   output job_chan_type head,
   input  logic         pop
);

   job_type              mem_ff [QueueDepth];
   logic [QueueIdxW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueueIdxW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueIdxW:0]   count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == (QueueIdxW+1)'(QueueDepth));
   assign head.valid = (count_ff != '0);
   assign head.job   = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QueueIdxW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QueueIdxW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QueueIdxW+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QueueIdxW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* sv/b64d_back.sv */
module b64d_back
   import b64d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  job_chan_type         head,
   output logic                 pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CharWidth-1:0] rsp_tdata,
   output logic [1:0]           rsp_tuser,
   output logic                 rsp_tlast
);

   logic                 valid_ff, valid_in;
   logic [1:0]           idx_ff, idx_in;
   logic [CharWidth-1:0] data_ff, data_in;
   logic                 has_data_ff, has_data_in;
   logic                 run_last_ff, run_last_in;
   logic                 done_ff, done_in;

   logic                 load;
   logic                 last_byte;
   logic [CharWidth-1:0] sel_byte;

   assign load      = head.valid && (!valid_ff || rsp_tready);
   assign last_byte = (idx_ff == head.job.last_idx);
   assign pop       = load && last_byte;

   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head.job.word[23:16];
         2'd1:    sel_byte = head.job.word[15:8];
         default: sel_byte = head.job.word[7:0];
      endcase
   end

   always_comb begin
      valid_in    = valid_ff;
      idx_in      = idx_ff;
      data_in     = data_ff;
      has_data_in = has_data_ff;
      run_last_in = run_last_ff;
      done_in     = done_ff;
      if (load) begin
         valid_in    = 1'b1;
         idx_in      = last_byte ? 2'd0 : idx_ff + 2'd1;
         data_in     = head.job.has_data ? sel_byte : '0;
         has_data_in = head.job.has_data;
         run_last_in = last_byte;
         done_in     = last_byte && head.job.done;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      has_data_ff <= has_data_in;
      run_last_ff <= run_last_in;
      done_ff     <= done_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = {run_last_ff, has_data_ff};
   assign rsp_tlast  = done_ff;

endmodule

/* sv/base64_stream_decoder.sv */
// Channel  Direction  Payload
// req_     in         tdata = char_code, tlast = end_of_message
// rsp_     out        tdata = byte_out, tuser = {run_last, byte_valid}, tlast = message_done
//
// One character is taken every cycle while the four-entry job queue has room.
// Each result beat comes from the output register, one byte per cycle while rsp_tready
// is high, so a character that completes a group yields three beats on the output side.
// Reset is synchronous and clears the group state, the queue and the output.
// A stalled output fills the queue first and then drops req_tready.
module base64_stream_decoder
   import b64d_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [CharWidth-1:0] req_tdata,  // Bits 7:0 char_code.
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [CharWidth-1:0] rsp_tdata,  // Bits 7:0 byte_out.
   output logic [1:0]           rsp_tuser,  // Bit 0 byte_valid, bit 1 run_last.
   output logic                 rsp_tlast
);

   job_chan_type push;
   job_chan_type head;
   logic         queue_full;
   logic         pop;

   b64d_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push)
   );

   b64d_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

/* verif/tb_base64_stream_decoder.sv */
module tb_base64_stream_decoder;
   import b64d_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned IdleLimit   = 2000;
   localparam int unsigned RandomChars = 180;
   localparam int unsigned DrainCycles = 16;
   localparam logic [6:0]  NoSextet    = 7'h40;
   localparam logic [7:0]  PadChar     = 8'h3d;

   class decode_scoreboard;
      typedef struct packed {
         logic [7:0] data;
         logic       valid;
         logic       done;
         logic       last;
      } byte_beat_type;

      byte_beat_type expected_bytes[$];
      logic [17:0]   held;
      logic [1:0]    held_count;
      logic          halted;
      int            mismatches;

      function new();
         held       = '0;
         held_count = '0;
         halted     = 1'b0;
         mismatches = 0;
      endfunction

      function logic [6:0] char_value(logic [7:0] c);
         if (c >= 8'h41 && c <= 8'h5a) return 7'(c - 8'h41);
         if (c >= 8'h61 && c <= 8'h7a) return 7'(c - 8'h61 + 8'd26);
         if (c >= 8'h30 && c <= 8'h39) return 7'(c - 8'h30 + 8'd52);
         if (c == 8'h2b) return 7'd62;
         if (c == 8'h2f) return 7'd63;
         return NoSextet;
      endfunction

      function void note_char(logic [7:0] c, logic eom);
         logic [6:0]    v;
         logic [23:0]   w;
         byte_beat_type beats[3];
         int            n;
         n = 0;
         if (!halted) begin
            v = char_value(c);
            if (v[6]) begin
               halted = 1'b1;
            end else if (held_count == 2'd3) begin
               w = {held, v[5:0]};
               beats[0] = {w[23:16], 1'b1, 2'b00};
               beats[1] = {w[15:8], 1'b1, 2'b00};
               beats[2] = {w[7:0], 1'b1, 2'b00};
               n = 3;
               held = '0;
               held_count = '0;
            end else begin
               held = {held[11:0], v[5:0]};
               held_count = held_count + 2'd1;
            end
         end
         if (eom) begin
            // A partial group is flushed with its missing low sextets taken as zero.
            w = (held_count == 2'd3) ? {held, 6'd0} : {held[11:0], 12'd0};
            if (held_count >= 2'd2) begin
               beats[n] = {w[23:16], 1'b1, 2'b00};
               n++;
            end
            if (held_count == 2'd3) begin
               beats[n] = {w[15:8], 1'b1, 2'b00};
               n++;
            end
            if (n == 0) begin
               beats[0] = '0;
               n = 1;
            end
            beats[n-1].done = 1'b1;
            held = '0;
            held_count = '0;
            halted = 1'b0;
         end
         if (n > 0) beats[n-1].last = 1'b1;
         for (int i = 0; i < n; i++) expected_bytes.push_back(beats[i]);
      endfunction

      function void check_beat(logic [7:0] data, logic [1:0] user, logic tlast);
         byte_beat_type want;
         if (expected_bytes.size() == 0) begin
            $display("%0t: unexpected beat byte_out=%h byte_valid=%b message_done=%b run_last=%b",
                     $time, data, user[0], tlast, user[1]);
            mismatches++;
            return;
         end
         want = expected_bytes.pop_front();
         if (want != {data, user[0], tlast, user[1]}) begin
            $display("%0t: mismatch expected byte_out=%h byte_valid=%b message_done=%b run_last=%b",
                     $time, want.data, want.valid, want.done, want.last);
            $display("%0t:          actual   byte_out=%h byte_valid=%b message_done=%b run_last=%b",
                     $time, data, user[0], tlast, user[1]);
            mismatches++;
         end
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction
   endclass

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [CharWidth-1:0] req_tdata  = '0;   // Bits 7:0 char_code.
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [CharWidth-1:0] rsp_tdata;         // Bits 7:0 byte_out.
   logic [1:0]           rsp_tuser;         // Bit 0 byte_valid, bit 1 run_last.
   logic                 rsp_tlast;

   decode_scoreboard sb = new();
   logic [7:0]       msg_chars[$];
   int               chars_sent = 0;
   int               burst_left = 0;
   int               idle_cycles = 0;
   int               ready_pct = 100;
   int               phase_cycle = 0;

   base64_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   always @(posedge clock) begin
      phase_cycle <= (phase_cycle == 63) ? 0 : phase_cycle + 1;
      if (phase_cycle == 63) begin
         case ($urandom_range(0, 4))
            0: ready_pct <= 100;
            1: ready_pct <= 85;
            2: ready_pct <= 60;
            3: ready_pct <= 35;
            default: ready_pct <= 100;
         endcase
      end
      rsp_tready <= ($urandom_range(1, 100) <= ready_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic logic [7:0] b64_char(int unsigned v);
      if (v < 26) return 8'(8'h41 + v);
      if (v < 52) return 8'(8'h61 + v - 26);
      if (v < 62) return 8'(8'h30 + v - 52);
      if (v == 62) return 8'h2b;
      return 8'h2f;
   endfunction

   task automatic send_char(input logic [7:0] c, input logic eom);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eom;
      do @(posedge clock); while (!req_tready);
      sb.note_char(c, eom);
      chars_sent++;
   endtask

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 5);
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_message();
      foreach (msg_chars[i]) begin
         pace();
         send_char(msg_chars[i], i == msg_chars.size() - 1);
      end
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic build_random_message();
      int unsigned len;
      msg_chars = {};
      if ($urandom_range(0, 9) < 8) begin
         len = $urandom_range(0, 11);
         repeat (len) msg_chars.push_back(b64_char($urandom_range(0, 63)));
         if (len % 4 == 2 && $urandom_range(0, 2) != 0) begin
            msg_chars.push_back(PadChar);
            if ($urandom_range(0, 1)) msg_chars.push_back(PadChar);
         end else if (len % 4 == 3 && $urandom_range(0, 1)) begin
            msg_chars.push_back(PadChar);
         end
         if (msg_chars.size() == 0) msg_chars.push_back(b64_char($urandom_range(0, 63)));
         if ($urandom_range(0, 5) == 0) begin
            msg_chars.insert($urandom_range(0, msg_chars.size() - 1), 8'($urandom_range(0, 255)));
         end
      end else begin
         len = $urandom_range(1, 6);
         repeat (len) begin
            if ($urandom_range(0, 1)) msg_chars.push_back(8'($urandom_range(0, 255)));
            else msg_chars.push_back(b64_char($urandom_range(0, 63)));
         end
      end
   endtask

   initial begin
      int directed_chars;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      msg_chars = {"T", "W", "F", "u"};
      send_message();
      msg_chars = {"A", "Z", "a", "z", "0", "9", "+", "/"};
      send_message();
      msg_chars = {"Q", "Q"};
      send_message();
      msg_chars = {"Q", "U", "I"};
      send_message();
      msg_chars = {"Q"};
      send_message();
      msg_chars = {"Q", "Q", "=", "="};
      send_message();
      msg_chars = {8'h80, "A", 8'hff};
      send_message();
      msg_chars = {PadChar};
      send_message();
      msg_chars = {8'h00};
      send_message();
      drain();

      directed_chars = chars_sent;
      while (chars_sent < directed_chars + RandomChars) begin
         build_random_message();
         send_message();
         if ($urandom_range(0, 9) == 0) drain();
      end

      drain();
      repeat (DrainCycles) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_stream_decoder.sv
verif/tb_base64_stream_decoder.sv
